/* src/sdma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake detector package
// Shared types and constants for the moving average shake detector.
// ----------------------------------------------------------------------------
package sdma_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [15:0] HOLDOFF_RESET = 16'd2000;
  localparam logic [15:0] MS_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic                operation;
    logic signed [15:0]  accel_x;
    logic signed [15:0]  accel_y;
    logic signed [15:0]  accel_z;
  } in_item_t;

  typedef struct packed {
    logic        shake;
    logic [15:0] dev_x;
    logic [15:0] dev_y;
    logic [15:0] dev_z;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH,
    ST_OUTPUT
  } state_t;

  // Request from the sequencer to the divider, and its status back.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/sdma_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface sdma_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/sdma_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample ring memory
// Synchronous RAM holding the last samples of all three axes per entry.
// ----------------------------------------------------------------------------
module sdma_ring import sdma_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [47:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [47:0]   rdata
);
  logic [47:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/sdma_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sdma_div import sdma_pkg::*; #(
  parameter int unsigned NW = 21,
  parameter int unsigned DW = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  div_ctrl_t            ctrl,
  input  logic signed [NW-1:0] numer,
  input  logic [DW-1:0]        denom,
  output div_stat_t            stat,
  output logic signed [NW-1:0] quot
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic          neg;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  assign shifted = {rem[DW-1:0], q[NW-1]};
  assign trial   = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= CW'(NW);
        neg   <= numer[NW-1];
        q     <= numer[NW-1] ? NW'(-numer) : numer;
        rem   <= '0;
        d     <= denom;
      end else if (busy) begin
        if (!trial[DW]) begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[NW-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};
  assign quot = neg ? NW'(-q) : q;

  property p_done_not_busy;
    @(posedge clk) disable iff (rst) !(done && busy);
  endproperty
  assert property (p_done_not_busy) else $error("divider done while busy");
  property p_no_restart;
    @(posedge clk) disable iff (rst) !(ctrl.start && busy);
  endproperty
  assert property (p_no_restart) else $error("divider restarted while busy");
  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  assert property (p_done_after_busy) else $error("done without run");
endmodule

/* src/shake_detector_moving_average_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake detector, moving average deviation
// Top level: sequencer, sample ring and shared divider.
// ----------------------------------------------------------------------------
// A tick request is accepted while idle, and ticks can follow back to back.
// A sample request goes through one ring read, an update, then the three axis
// averages through one shared bit-serial divider of SW bits, where
// SW = 17 + log2(RING_DEPTH) is the width of the running sums. The result is then
// loaded into the output register, and the next request can be accepted in the
// cycle after. Unless the output register is held, the divider sets the rate.
// While a result waits in the output register, ticks and one more sample are
// still accepted; that sample then waits until the output register is free.
// The ring has no reset; an old entry is used only once the ring is full, so only entries already written are used.
module shake_detector_moving_average_core import sdma_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  sdma_if.sink                   in_ch,
  sdma_if.source                 out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]            cfg_data
);
  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = 16 + AW + 1;

  logic [15:0] x_limit, y_limit, z_limit, holdoff_ms;
  logic [15:0] elapsed_ms;
  logic signed [SW-1:0] sum_x, sum_y, sum_z;
  logic [AW-1:0] write_slot;
  logic [FW-1:0] fill_count;
  state_t state, state_next;
  in_item_t  item;
  out_item_t result;
  logic [1:0] axis;
  logic [47:0] old_entry;
  logic [15:0] dev_x, dev_y, dev_z;
  logic shake;
  logic out_valid;
  logic out_free;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;
  logic signed [SW-1:0] div_numer, quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= '0; y_limit <= '0; z_limit <= '0;
      holdoff_ms <= HOLDOFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_LIMIT: x_limit <= cfg_data;
        REG_Y_LIMIT: y_limit <= cfg_data;
        REG_Z_LIMIT: z_limit <= cfg_data;
        REG_HOLDOFF: holdoff_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  sdma_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_ring (
    .clk(clk), .we(state == ST_UPDATE), .waddr(write_slot),
    .wdata({item.accel_x, item.accel_y, item.accel_z}),
    .raddr(write_slot), .rdata(old_entry)
  );

  always_comb begin
    case (axis)
      2'd0:    div_numer = sum_x;
      2'd1:    div_numer = sum_y;
      default: div_numer = sum_z;
    endcase
  end

  sdma_div #(.NW(SW), .DW(FW)) u_div (
    .clk(clk), .rst(rst), .ctrl(div_ctrl), .numer(div_numer),
    .denom(fill_count), .stat(div_stat), .quot(quot)
  );

  logic full;
  assign full = (fill_count == FW'(RING_DEPTH));

  // The output register can take a new result when it is empty or being read.
  assign out_free = !out_valid || out_ch.ready;

  logic signed [15:0] cur_sample;
  always_comb begin
    case (axis)
      2'd0:    cur_sample = item.accel_x;
      2'd1:    cur_sample = item.accel_y;
      default: cur_sample = item.accel_z;
    endcase
  end
  logic signed [SW:0] diff;
  logic [SW:0] mag;
  logic [15:0] dev;
  assign diff = (SW+1)'(quot) - (SW+1)'(cur_sample);
  assign mag  = diff[SW] ? (SW+1)'(-diff) : diff;
  assign dev  = (mag > (SW+1)'(16'hFFFF)) ? 16'hFFFF : mag[15:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_ch.valid) state_next = (in_ch.data.operation == OP_TICK) ?
                   ST_IDLE : ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_stat.done) state_next = (axis == 2'd2) ? ST_FINISH : ST_DIVIDE;
      ST_FINISH: state_next = ST_OUTPUT;
      ST_OUTPUT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  logic div_go;
  always_comb begin
    in_ch.ready  = (state == ST_IDLE);
    out_ch.valid = out_valid;
    out_ch.data  = result;
    div_ctrl.start = div_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      elapsed_ms <= '0;
      sum_x <= '0; sum_y <= '0; sum_z <= '0;
      write_slot <= '0;
      fill_count <= '0;
      axis <= '0;
      div_go <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      div_go <= 1'b0;
      if (state == ST_OUTPUT && out_free) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_ch.valid) begin
          item <= in_ch.data;
          if (in_ch.data.operation == OP_TICK && elapsed_ms != MS_MAX)
            elapsed_ms <= elapsed_ms + 1'b1;
        end
        ST_UPDATE: begin
          if (full) begin
            sum_x <= sum_x - SW'($signed(old_entry[47:32])) + SW'(item.accel_x);
            sum_y <= sum_y - SW'($signed(old_entry[31:16])) + SW'(item.accel_y);
            sum_z <= sum_z - SW'($signed(old_entry[15:0]))  + SW'(item.accel_z);
          end else begin
            sum_x <= sum_x + SW'(item.accel_x);
            sum_y <= sum_y + SW'(item.accel_y);
            sum_z <= sum_z + SW'(item.accel_z);
            fill_count <= fill_count + 1'b1;
          end
          write_slot <= (write_slot == AW'(RING_DEPTH - 1)) ? '0 : write_slot + 1'b1;
          axis <= '0;
          div_go <= 1'b1;
        end
        ST_DIVIDE: if (div_stat.done) begin
          case (axis)
            2'd0:    dev_x <= dev;
            2'd1:    dev_y <= dev;
            default: dev_z <= dev;
          endcase
          if (axis != 2'd2) begin
            axis <= axis + 1'b1;
            div_go <= 1'b1;
          end
        end
        ST_FINISH:
          shake <= (elapsed_ms > holdoff_ms) && ((dev_x > x_limit) ||
            (dev_y > y_limit) || (dev_z > z_limit));
        ST_OUTPUT: if (out_free) begin
          result <= '{shake: shake, dev_x: dev_x, dev_y: dev_y, dev_z: dev_z};
        end
        default: ;
      endcase
    end
  end

  property p_fill_bound;
    @(posedge clk) disable iff (rst) fill_count <= FW'(RING_DEPTH);
  endproperty
  assert property (p_fill_bound) else $error("fill count overrun");
  property p_out_hold;
    @(posedge clk) disable iff (rst) (out_ch.valid && !out_ch.ready) |=> out_ch.valid;
  endproperty
  assert property (p_out_hold) else $error("result dropped");
  property p_out_stable;
    @(posedge clk) disable iff (rst)
      (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data);
  endproperty
  assert property (p_out_stable) else $error("result changed while waiting");
  property p_div_only_divide;
    @(posedge clk) disable iff (rst) div_stat.busy |-> (state == ST_DIVIDE);
  endproperty
  assert property (p_div_only_divide) else $error("divider busy outside divide");
endmodule

/* tb/tb_shake_detector_moving_average_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake detector testbench
// Drives samples and millisecond ticks into the moving average shake detector
// under random stalls on both channels, predicts every deviation and shake
// flag, and compares each result in order against the prediction.
// ----------------------------------------------------------------------------
module tb_shake_detector_moving_average_core;
  import sdma_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned DRAIN_CYCLES = 100;

  class shake_scoreboard;
    logic signed [15:0] hist_x[DEPTH];
    logic signed [15:0] hist_y[DEPTH];
    logic signed [15:0] hist_z[DEPTH];
    longint sum_x, sum_y, sum_z;
    int unsigned slot, held, elapsed;
    logic [15:0] lim_x, lim_y, lim_z, holdoff;
    out_item_t pending[$];
    int unsigned mismatches;

    function void clear();
      sum_x = 0; sum_y = 0; sum_z = 0;
      slot = 0; held = 0; elapsed = 0;
      lim_x = 0; lim_y = 0; lim_z = 0;
      holdoff = HOLDOFF_RESET;
      pending.delete();
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_X_LIMIT: lim_x = val;
        REG_Y_LIMIT: lim_y = val;
        REG_Z_LIMIT: lim_z = val;
        REG_HOLDOFF: holdoff = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] abs_dev(longint sum, logic signed [15:0] s);
      longint avg, d;
      avg = sum / longint'(held);
      d = avg - longint'(s);
      if (d < 0) d = -d;
      if (d > 65535) d = 65535;
      return d[15:0];
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      if (it.operation == OP_TICK) begin
        if (elapsed < 65535) elapsed++;
        return;
      end
      // Once the ring is full, the oldest sample leaves the sum first.
      if (held >= DEPTH) begin
        sum_x -= hist_x[slot];
        sum_y -= hist_y[slot];
        sum_z -= hist_z[slot];
      end else begin
        held++;
      end
      hist_x[slot] = it.accel_x;
      hist_y[slot] = it.accel_y;
      hist_z[slot] = it.accel_z;
      sum_x += it.accel_x;
      sum_y += it.accel_y;
      sum_z += it.accel_z;
      slot = (slot + 1) % DEPTH;
      r.dev_x = abs_dev(sum_x, it.accel_x);
      r.dev_y = abs_dev(sum_y, it.accel_y);
      r.dev_z = abs_dev(sum_z, it.accel_z);
      r.shake = (elapsed > holdoff) &&
                (r.dev_x > lim_x || r.dev_y > lim_y || r.dev_z > lim_z);
      pending.push_back(r);
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result shake=%0b dev=%0d/%0d/%0d",
                   got.shake, got.dev_x, got.dev_y, got.dev_z);
        return;
      end
      want = pending.pop_front();
      if (got.shake !== want.shake || got.dev_x !== want.dev_x ||
          got.dev_y !== want.dev_y || got.dev_z !== want.dev_z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected shake=%0b dev=%0d/%0d/%0d, got shake=%0b dev=%0d/%0d/%0d",
                   want.shake, want.dev_x, want.dev_y, want.dev_z,
                   got.shake, got.dev_x, got.dev_y, got.dev_z);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_X_LIMIT;
  logic [15:0] cfg_data = '0;

  sdma_if #(.T(in_item_t))  in_ch ();
  sdma_if #(.T(out_item_t)) out_ch ();

  shake_detector_moving_average_core #(.RING_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  shake_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    out_ch.ready <= 1'b0;
  end

  // Receiver: checks every accepted result and stalls as configured.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
      if (recv_hold > 0) begin
        recv_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic go_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [15:0] hold);
    go_quiet();
    write_reg(REG_X_LIMIT, x);
    write_reg(REG_Y_LIMIT, y);
    write_reg(REG_Z_LIMIT, z);
    write_reg(REG_HOLDOFF, hold);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t make_sample(logic [15:0] x, logic [15:0] y,
                                           logic [15:0] z);
    in_item_t it;
    it.operation = OP_SAMPLE;
    it.accel_x = x;
    it.accel_y = y;
    it.accel_z = z;
    return it;
  endfunction

  function automatic in_item_t make_tick();
    in_item_t it;
    it = make_sample(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)));
    it.operation = OP_TICK;
    return it;
  endfunction

  // Mostly a steady reading with noise, some spikes, some fully random values.
  function automatic logic [15:0] rand_axis(logic [15:0] base);
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 6) return base + 16'($urandom_range(400)) - 16'd200;
    if (kind < 8) return base + 16'($urandom_range(40000)) - 16'd20000;
    return 16'($urandom_range(65535));
  endfunction

  task automatic random_run(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) send(make_tick());
      else send(make_sample(rand_axis(16'd1000), rand_axis(16'hFE0C),
                            rand_axis(16'd16000)));
    end
  endtask

  task automatic random_phase(int unsigned count);
    write_all(16'($urandom_range(3000)), 16'($urandom_range(3000)),
              16'($urandom_range(3000)), 16'($urandom_range(100)));
    random_run(count / 2);
    write_all(16'($urandom_range(65535)), 16'($urandom_range(500)),
              16'($urandom_range(3000)), 16'($urandom_range(400)));
    random_run(count - count / 2);
  endtask

  initial begin
    sb.clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default holdoff still pending: first sample gives zero deviation.
    send(make_sample(16'h7FFF, 16'h8000, 16'h0000));
    send(make_sample(16'h8000, 16'h7FFF, 16'hFFFF));
    send(make_tick());
    send(make_sample(16'h0000, 16'h0000, 16'h7FFF));
    send(make_sample(16'h7FFF, 16'h7FFF, 16'h8000));

    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(make_tick());
    send(make_sample(16'h8000, 16'h8000, 16'h8000));
    send(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));

    // With zero limits and no holdoff, any deviation is a shake.
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(make_tick());
    for (int i = 0; i < 18; i++)
      send(make_sample(i[0] ? 16'h7FFF : 16'h8000, 16'(i * 1000), 16'h0005));

    send_idle_pct = 32; recv_idle_pct = 50;
    random_phase(330);
    send_idle_pct = 50; recv_idle_pct = 32;
    random_phase(330);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(250);

    // Long receiver stall while requests keep coming, so the input backs up.
    recv_hold = 500;
    random_run(40);

    // Put the holdoff a few ticks ahead, then cross it with mixed traffic.
    write_all(16'd100, 16'd100, 16'd100, 16'(sb.elapsed + 8));
    random_run(60);
    write_all(16'd0, 16'd0, 16'd0, 16'hFFFF);
    for (int i = 0; i < 10; i++)
      send(make_sample(rand_axis(16'd0), rand_axis(16'd0), rand_axis(16'd0)));

    go_quiet();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
